[hw/rtl/pbcd_pkg.sv]
package pbcd_pkg;

   localparam logic OP_TO_BCD = 1'b0;
   localparam logic OP_TO_BIN = 1'b1;

   localparam logic [31:0] NARROW_MAX  = 32'd9999;
   localparam logic [31:0] WIDE_MAX    = 32'd99999999;
   localparam logic [13:0] HALF_SCALE  = 14'd10000;
   localparam logic [15:0] RECIP_10K   = 16'd53687;
   localparam int          RECIP_10K_SH = 29;
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_100_SH = 19;
   localparam logic [3:0]  NIBBLE_MASK = 4'hf;

   typedef struct packed {
      logic        op;
      logic        ovf;
      logic [13:0] q;
      logic [14:0] rem;
      logic [27:0] bin;
   } front_type;

   typedef struct packed {
      logic        op;
      logic        ovf;
      logic [27:0] bin;
      logic [13:0] hi;
      logic [13:0] lo;
      logic [6:0]  hq_hi;
      logic [6:0]  hq_lo;
   } split_type;

   // nibble weights 1, 10, 100, 1000; nibbles above 9 taken as they are
   function automatic logic [14:0] unpack_four(input logic [15:0] w);
      return 15'(w[3:0] & NIBBLE_MASK) + 15'(w[7:4] & NIBBLE_MASK) * 15'd10
           + 15'(w[11:8] & NIBBLE_MASK) * 15'd100 + 15'(w[15:12] & NIBBLE_MASK) * 15'd1000;
   endfunction

   // 0..99 to two BCD digits
   function automatic logic [7:0] two_digits(input logic [6:0] x);
      logic [13:0] t;
      logic [3:0]  tens;
      logic [3:0]  ones;
      t    = 14'(x) * 14'd103;
      tens = t[13:10];
      ones = 4'(x - 7'(tens) * 7'd10);
      return {tens, ones};
   endfunction

endpackage

[hw/rtl/pbcd_front.sv]
module pbcd_front import pbcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic        in_op,
   input  logic        in_wide,
   input  logic [31:0] in_value,
   output logic        out_valid,
   input  logic        out_ready,
   output front_type   out_data
);

   logic        a_valid_ff, a_valid_in;
   logic        a_op_ff, a_wide_ff, a_ovf_ff;
   logic [26:0] a_value_ff;
   logic [42:0] a_prod_ff;
   logic [14:0] a_bin_hi_ff, a_bin_lo_ff;
   logic        a_ovf_in;
   logic        a_ready, b_ready;

   logic        b_valid_ff, b_valid_in;
   front_type   b_data_ff, b_data_in;
   logic [13:0] a_q;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign a_valid_in = a_ready ? in_valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   assign a_ovf_in = (in_op == OP_TO_BCD) &&
                     (in_wide ? (in_value > WIDE_MAX) : (in_value > NARROW_MAX));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_op_ff     <= in_op;
         a_wide_ff   <= in_wide;
         a_ovf_ff    <= a_ovf_in;
         a_value_ff  <= in_value[26:0];
         a_prod_ff   <= 43'(in_value[26:0]) * 43'(RECIP_10K);
         a_bin_lo_ff <= unpack_four(in_value[15:0]);
         a_bin_hi_ff <= unpack_four(in_value[31:16]);
      end
   end

   // quotient estimate is exact or one low
   assign a_q = a_prod_ff[RECIP_10K_SH +: 14];

   always_comb begin
      b_data_in.op  = a_op_ff;
      b_data_in.ovf = a_ovf_ff;
      b_data_in.q   = a_q;
      b_data_in.rem = 15'(a_value_ff - 27'(a_q) * 27'(HALF_SCALE));
      b_data_in.bin = a_wide_ff ? 28'(a_bin_hi_ff) * 28'(HALF_SCALE) + 28'(a_bin_lo_ff)
                                : 28'(a_bin_lo_ff);
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

[hw/rtl/pbcd_split.sv]
module pbcd_split import pbcd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  front_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output split_type out_data
);

   logic        c_valid_ff, c_valid_in;
   logic        c_op_ff, c_ovf_ff;
   logic [27:0] c_bin_ff;
   logic [13:0] c_hi_ff, c_lo_ff, c_hi_in, c_lo_in;
   logic        c_ready, d_ready;
   logic        carry;

   logic        d_valid_ff, d_valid_in;
   split_type   d_data_ff, d_data_in;
   logic [26:0] prod_hi, prod_lo;

   assign d_ready  = !d_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;

   assign c_valid_in = c_ready ? in_valid : c_valid_ff;
   assign d_valid_in = d_ready ? c_valid_ff : d_valid_ff;

   assign carry   = in_data.rem >= 15'(HALF_SCALE);
   assign c_hi_in = carry ? in_data.q + 14'd1 : in_data.q;
   assign c_lo_in = carry ? 14'(in_data.rem - 15'(HALF_SCALE)) : in_data.rem[13:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready && in_valid) begin
         c_op_ff  <= in_data.op;
         c_ovf_ff <= in_data.ovf;
         c_bin_ff <= in_data.bin;
         c_hi_ff  <= c_hi_in;
         c_lo_ff  <= c_lo_in;
      end
   end

   // divide by 100, exact below 10000
   assign prod_hi = 27'(c_hi_ff) * 27'(RECIP_100);
   assign prod_lo = 27'(c_lo_ff) * 27'(RECIP_100);

   always_comb begin
      d_data_in.op    = c_op_ff;
      d_data_in.ovf   = c_ovf_ff;
      d_data_in.bin   = c_bin_ff;
      d_data_in.hi    = c_hi_ff;
      d_data_in.lo    = c_lo_ff;
      d_data_in.hq_hi = prod_hi[RECIP_100_SH +: 7];
      d_data_in.hq_lo = prod_lo[RECIP_100_SH +: 7];
   end

   always_ff @(posedge clock) begin
      if (d_ready && c_valid_ff) begin
         d_data_ff <= d_data_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_data_ff;

endmodule

[hw/rtl/pbcd_digits.sv]
module pbcd_digits import pbcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  split_type   in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] out_result,
   output logic        out_ok
);

   logic        e_valid_ff, e_valid_in;
   logic        e_op_ff, e_ovf_ff;
   logic [27:0] e_bin_ff;
   logic [6:0]  e_p3_ff, e_p2_ff, e_p1_ff, e_p0_ff;
   logic        e_ready, f_ready;

   logic        f_valid_ff, f_valid_in;
   logic [31:0] f_result_ff, f_result_in;
   logic        f_ok_ff;

   assign f_ready  = !f_valid_ff || out_ready;
   assign e_ready  = !e_valid_ff || f_ready;
   assign in_ready = e_ready;

   assign e_valid_in = e_ready ? in_valid : e_valid_ff;
   assign f_valid_in = f_ready ? e_valid_ff : f_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= e_valid_in;
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (e_ready && in_valid) begin
         e_op_ff  <= in_data.op;
         e_ovf_ff <= in_data.ovf;
         e_bin_ff <= in_data.bin;
         e_p3_ff  <= in_data.hq_hi;
         e_p2_ff  <= 7'(in_data.hi - 14'(in_data.hq_hi) * 14'd100);
         e_p1_ff  <= in_data.hq_lo;
         e_p0_ff  <= 7'(in_data.lo - 14'(in_data.hq_lo) * 14'd100);
      end
   end

   always_comb begin
      if (e_op_ff == OP_TO_BIN) begin
         f_result_in = 32'(e_bin_ff);
      end else if (e_ovf_ff) begin
         f_result_in = 32'd0;
      end else begin
         f_result_in = {two_digits(e_p3_ff), two_digits(e_p2_ff),
                        two_digits(e_p1_ff), two_digits(e_p0_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (f_ready && e_valid_ff) begin
         f_result_ff <= f_result_in;
         f_ok_ff     <= !e_ovf_ff;
      end
   end

   assign out_valid  = f_valid_ff;
   assign out_result = f_result_ff;
   assign out_ok     = f_ok_ff;

endmodule

[hw/rtl/packed_bcd_converter_top.sv]
// Binary <-> packed BCD converter, six register stages.
// Throughput: one beat per cycle when not stalled; each stage advances
// when it is empty or its successor advances, so rsp_tready low stalls
// the pipe without loss.
// Reset: synchronous, active high; clears all stage valid bits.
module packed_bcd_converter_top import pbcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [0] op, [1] wide
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result
   output logic        rsp_tuser    // [0] ok
);

   logic      front_valid, front_ready;
   front_type front_data;
   logic      split_valid, split_ready;
   split_type split_data;

   pbcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser[0]),
      .in_wide   (req_tuser[1]),
      .in_value  (req_tdata),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   pbcd_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (split_valid),
      .out_ready (split_ready),
      .out_data  (split_data)
   );

   pbcd_digits u_digits (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (split_valid),
      .in_ready   (split_ready),
      .in_data    (split_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_tdata),
      .out_ok     (rsp_tuser)
   );

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("overflow beat with nonzero result");

   a_bin_no_ovf: assert property (@(posedge clock) disable iff (reset)
      front_valid && front_data.op == OP_TO_BIN |-> !front_data.ovf)
      else $error("overflow flagged on BCD to binary");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      front_valid && front_data.op == OP_TO_BCD && !front_data.ovf
         |-> front_data.rem < 15'(2 * HALF_SCALE))
      else $error("quotient estimate off by more than one");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("output valid right after reset");

endmodule

[tb/tb_packed_bcd_converter_top.sv]
`timescale 1ns / 1ps

module tb_packed_bcd_converter_top;
   import pbcd_pkg::*;

   localparam logic FOUR_DIGITS  = 1'b0;
   localparam logic EIGHT_DIGITS = 1'b1;
   localparam int   ITEMS_PER_PHASE = 450;
   localparam int   STALL_LIMIT     = 4000;
   localparam int   DRAIN_CYCLES    = 24;

   typedef struct packed {
      logic        wide;
      logic        op;
      logic [31:0] value;
   } conv_req_type;

   typedef struct packed {
      logic [31:0] result;
      logic        ok;
   } conv_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic [1:0]  req_tuser = '0;   // [0] op, [1] wide
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] result
   logic        rsp_tuser;        // [0] ok

   conv_req_type conversions_to_send[$];
   conv_rsp_type awaited_conversions[$];

   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   logic sender_hold = 1'b0;
   int error_count = 0;
   int idle_cycles = 0;
   int to_bcd_beats = 0;
   int to_bin_beats = 0;
   int out_of_range_seen = 0;
   int results_checked = 0;

   packed_bcd_converter_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic conv_rsp_type predict_conversion(conv_req_type r);
      conv_rsp_type o;
      int unsigned  v;
      int unsigned  acc;
      int unsigned  limit;
      int           i;
      o.result = '0;
      o.ok     = 1'b1;
      if (r.op == OP_TO_BCD) begin
         limit = (r.wide == EIGHT_DIGITS) ? 32'd99999999 : 32'd9999;
         if (r.value > limit) begin
            o.ok = 1'b0;
         end else begin
            v = r.value;
            for (i = 0; i < 8; i++) begin
               o.result[4*i +: 4] = 4'(v % 10);
               v = v / 10;
            end
         end
      end else begin
         acc = 0;
         for (i = (r.wide == EIGHT_DIGITS) ? 7 : 3; i >= 0; i--) begin
            acc = acc * 10 + r.value[4*i +: 4];
         end
         o.result = acc;
      end
      return o;
   endfunction

   task automatic queue_conversion(input logic op, input logic wide, input logic [31:0] value);
      conv_req_type r;
      r.op    = op;
      r.wide  = wide;
      r.value = value;
      conversions_to_send.push_back(r);
   endtask

   task automatic queue_random_conversion();
      logic        op;
      logic        wide;
      logic [31:0] value;
      logic [31:0] limit;
      int          i;
      op    = 1'($urandom);
      wide  = 1'($urandom);
      limit = (wide == EIGHT_DIGITS) ? WIDE_MAX : NARROW_MAX;
      case ($urandom_range(0, 5))
         0: begin
            value = $urandom;
         end
         1: begin
            value = $urandom_range(0, limit);
         end
         2: begin
            value = limit - 3 + $urandom_range(0, 6);
         end
         3: begin
            for (i = 0; i < 8; i++) value[4*i +: 4] = 4'($urandom_range(0, 9));
         end
         4: begin
            value = $urandom;
            value[4*$urandom_range(0, 7) +: 4] = 4'($urandom_range(10, 15));
         end
         default: begin
            value = $urandom_range(0, 255);
         end
      endcase
      queue_conversion(op, wide, value);
   endtask

   // sender
   always @(posedge clock) begin : req_driver
      conv_req_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            r.value = req_tdata;
            r.op    = req_tuser[0];
            r.wide  = req_tuser[1];
            awaited_conversions.push_back(predict_conversion(r));
            if (r.op == OP_TO_BCD) to_bcd_beats++;
            else to_bin_beats++;
         end
         if (!req_tvalid || req_tready) begin
            if (conversions_to_send.size() > 0 && !sender_hold &&
                $urandom_range(0, 99) >= sender_idle_pct) begin
               r = conversions_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= r.value;
               req_tuser  <= {r.wide, r.op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin : rsp_monitor
      conv_rsp_type exp_rsp;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_conversions.size() == 0) begin
               error_count++;
               $display("%0t: unexpected rsp beat, got result %h ok %b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               exp_rsp = awaited_conversions.pop_front();
               results_checked++;
               if (!exp_rsp.ok) out_of_range_seen++;
               if (rsp_tdata !== exp_rsp.result || rsp_tuser !== exp_rsp.ok) begin
                  error_count++;
                  $display("%0t: rsp mismatch, expected result %h ok %b, got result %h ok %b",
                           $time, exp_rsp.result, exp_rsp.ok, rsp_tdata, rsp_tuser);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, awaited_conversions.size());
            $display("== FAIL ==");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      int phase;
      int n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      queue_conversion(OP_TO_BCD, FOUR_DIGITS,  32'd0);
      queue_conversion(OP_TO_BCD, FOUR_DIGITS,  32'd9999);
      queue_conversion(OP_TO_BCD, FOUR_DIGITS,  32'd10000);
      queue_conversion(OP_TO_BCD, FOUR_DIGITS,  32'hffff_ffff);
      queue_conversion(OP_TO_BCD, FOUR_DIGITS,  32'h0001_0000);
      queue_conversion(OP_TO_BCD, FOUR_DIGITS,  32'd1234);
      queue_conversion(OP_TO_BCD, EIGHT_DIGITS, 32'd0);
      queue_conversion(OP_TO_BCD, EIGHT_DIGITS, 32'd99999999);
      queue_conversion(OP_TO_BCD, EIGHT_DIGITS, 32'd100000000);
      queue_conversion(OP_TO_BCD, EIGHT_DIGITS, 32'hffff_ffff);
      queue_conversion(OP_TO_BCD, EIGHT_DIGITS, 32'd10000);
      queue_conversion(OP_TO_BCD, EIGHT_DIGITS, 32'd87654321);
      queue_conversion(OP_TO_BIN, FOUR_DIGITS,  32'h0000_0000);
      queue_conversion(OP_TO_BIN, FOUR_DIGITS,  32'h0000_9999);
      queue_conversion(OP_TO_BIN, FOUR_DIGITS,  32'h0000_ffff);
      queue_conversion(OP_TO_BIN, FOUR_DIGITS,  32'hffff_1234);
      queue_conversion(OP_TO_BIN, FOUR_DIGITS,  32'h5a5a_a0b0);
      queue_conversion(OP_TO_BIN, EIGHT_DIGITS, 32'h0000_0000);
      queue_conversion(OP_TO_BIN, EIGHT_DIGITS, 32'h9999_9999);
      queue_conversion(OP_TO_BIN, EIGHT_DIGITS, 32'hffff_ffff);
      queue_conversion(OP_TO_BIN, EIGHT_DIGITS, 32'ha0b0_c0d0);
      queue_conversion(OP_TO_BIN, EIGHT_DIGITS, 32'h1234_5678);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 79; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 79; end
            default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
         endcase
         for (n = 0; n < ITEMS_PER_PHASE; n++) queue_random_conversion();
         if (phase == 2) begin
            // hold off new beats until the pipe has fully drained
            while (conversions_to_send.size() > ITEMS_PER_PHASE / 2) @(posedge clock);
            sender_hold = 1'b1;
            do @(posedge clock); while (req_tvalid || awaited_conversions.size() > 0);
            sender_hold = 1'b0;
         end
         while (conversions_to_send.size() > 0) @(posedge clock);
      end

      do @(posedge clock);
      while (req_tvalid || conversions_to_send.size() > 0 || awaited_conversions.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results: %0d binary-to-BCD beats (%0d out of range),",
               results_checked, to_bcd_beats, out_of_range_seen);
      $display("%0d BCD-to-binary beats; four idle/stall mixes plus a full drain mid-run",
               to_bin_beats);
      if (error_count == 0 && awaited_conversions.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[packed_bcd_converter_top.f]
hw/rtl/pbcd_pkg.sv
hw/rtl/pbcd_front.sv
hw/rtl/pbcd_split.sv
hw/rtl/pbcd_digits.sv
hw/rtl/packed_bcd_converter_top.sv
tb/tb_packed_bcd_converter_top.sv
